// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is asserted.
`define MPD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define MPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define MPD_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define MPD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: hw/rtl/mpd_pkg.sv
// Package: types and codes of the MQTT packet deframer.
`timescale 1ns / 1ps

package mpd_pkg;

  // Command codes
  localparam logic CMD_BYTE  = 1'b0;
  localparam logic CMD_RESET = 1'b1;

  // Packet types (upper nibble of the fixed header)
  localparam logic [3:0] TYPE_CONNACK = 4'd2;
  localparam logic [3:0] TYPE_PUBLISH = 4'd3;

  // Byte roles
  localparam logic [2:0] ROLE_HEADER  = 3'd0;
  localparam logic [2:0] ROLE_LENGTH  = 3'd1;
  localparam logic [2:0] ROLE_TLEN    = 3'd2;
  localparam logic [2:0] ROLE_TOPIC   = 3'd3;
  localparam logic [2:0] ROLE_PID     = 3'd4;
  localparam logic [2:0] ROLE_PAYLOAD = 3'd5;
  localparam logic [2:0] ROLE_OTHER   = 3'd6;
  localparam logic [2:0] ROLE_DISCARD = 3'd7;

  // Events
  localparam logic [2:0] EV_NONE        = 3'd0;
  localparam logic [2:0] EV_CONNACK_OK  = 3'd1;
  localparam logic [2:0] EV_CONNACK_REJ = 3'd2;
  localparam logic [2:0] EV_PUB_DONE    = 3'd3;
  localparam logic [2:0] EV_PUB_DROP    = 3'd4;
  localparam logic [2:0] EV_LEN_ERR     = 3'd5;
  localparam logic [2:0] EV_OTHER_DONE  = 3'd6;

  localparam logic [1:0] QOS_1 = 2'd1;

  // Remaining length is four 7-bit groups
  localparam int unsigned LEN_W = 28;

  typedef enum logic [8:0] {
    PH_HEADER  = 9'b000000001,
    PH_LENGTH  = 9'b000000010,
    PH_TLEN_HI = 9'b000000100,
    PH_TLEN_LO = 9'b000001000,
    PH_TOPIC   = 9'b000010000,
    PH_PID_HI  = 9'b000100000,
    PH_PID_LO  = 9'b001000000,
    PH_PAYLOAD = 9'b010000000,
    PH_OTHER   = 9'b100000000
  } phase_t;

  typedef struct packed {
    logic       command;
    logic [7:0] rx_byte;
  } mpd_item_t;

  typedef struct packed {
    logic [2:0]  byte_role;
    logic [7:0]  data_byte;
    logic [3:0]  packet_type;
    logic [2:0]  event_res;
    logic        packet_end;
    logic [1:0]  qos_level;
    logic        ack_needed;
    logic [15:0] packet_id;
  } mpd_result_t;

endpackage

// File: hw/rtl/mpd_ifs.sv
// Stream interfaces: received-byte channel and result channel.
`timescale 1ns / 1ps

interface mpd_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] rx_byte;

  modport source (output valid, output command, output rx_byte, input ready);
  modport sink   (input valid, input command, input rx_byte, output ready);
endinterface

interface mpd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  byte_role;
  logic [7:0]  data_byte;
  logic [3:0]  packet_type;
  logic [2:0]  event_res;
  logic        packet_end;
  logic [1:0]  qos_level;
  logic        ack_needed;
  logic [15:0] packet_id;

  modport source (output valid, output byte_role, output data_byte, output packet_type,
                  output event_res, output packet_end, output qos_level,
                  output ack_needed, output packet_id, input ready);
  modport sink   (input valid, input byte_role, input data_byte, input packet_type,
                  input event_res, input packet_end, input qos_level,
                  input ack_needed, input packet_id, output ready);
endinterface

// File: hw/rtl/mqtt_packet_deframer_top.sv
// Top level of the MQTT 3.1.1 packet deframer.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Usage
//   in_ch  : received beats (command, rx_byte), valid/ready. command 0 carries
//            one link byte, command 1 is a connection reset that clears all
//            parser state and yields no result beat.
//   out_ch : one result beat per received byte: byte role, the byte itself,
//            packet type, event, packet end, QoS, PUBACK request, packet id.
// Path: a byte accepted on in_ch passes the input register, then parser
//   logic into the result register, before it appears on out_ch.
// Throughput: one beat per cycle while out_ch takes every beat. The parser
//   state updates once per byte; the single result register is the limit.
// Stall: while out_ch is not taken the result register holds, the input
//   register fills, and in_ch.ready drops until the result beat drains.
// Reset: rst_n (synchronous, active low) empties both registers and returns
//   the parser to waiting for a fixed header. After a fifth length byte the
//   block tags every byte as discarded until a reset command arrives.

module mqtt_packet_deframer_top import mpd_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  mpd_in_if.sink   in_ch,
  mpd_out_if.source out_ch
);

  logic        in_valid_r;
  mpd_item_t   in_item_r;
  logic        can_load;
  logic        process;
  logic        res_valid;
  mpd_result_t res;
  mpd_result_t out_data;
  logic        out_valid;

  // input register advances whenever the result register can take its beat
  assign process     = in_valid_r && can_load;
  assign in_ch.ready = !in_valid_r || can_load;
  assign res_valid   = process && (in_item_r.command == CMD_BYTE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_item_r.command <= in_ch.command;
      in_item_r.rx_byte <= in_ch.rx_byte;
    end
  end

  mpd_parser u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (process),
    .item  (in_item_r),
    .res   (res)
  );

  mpd_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_valid (res_valid),
    .load_data  (res),
    .can_load   (can_load),
    .out_ready  (out_ch.ready),
    .out_valid  (out_valid),
    .out_data   (out_data)
  );

  assign out_ch.valid       = out_valid;
  assign out_ch.byte_role   = out_data.byte_role;
  assign out_ch.data_byte   = out_data.data_byte;
  assign out_ch.packet_type = out_data.packet_type;
  assign out_ch.event_res   = out_data.event_res;
  assign out_ch.packet_end  = out_data.packet_end;
  assign out_ch.qos_level   = out_data.qos_level;
  assign out_ch.ack_needed  = out_data.ack_needed;
  assign out_ch.packet_id   = out_data.packet_id;

  // a packet end always carries an event
  `MPD_ASSERT_SAME(a_end_has_event, clk, rst_n,
    out_valid && out_data.packet_end, out_data.event_res != EV_NONE)

  // a PUBACK request only on a done QoS 1 publish
  `MPD_ASSERT_SAME(a_ack_only_qos1, clk, rst_n,
    out_valid && out_data.ack_needed,
    out_data.event_res == EV_PUB_DONE && out_data.qos_level == QOS_1)

  // a reset command leaves no result beat behind
  `MPD_ASSERT_NEXT(a_reset_no_beat, clk, rst_n,
    process && in_item_r.command == CMD_RESET, !out_valid)

  // every processed byte lands in the result register unchanged
  `MPD_ASSERT_NEXT(a_byte_passed, clk, rst_n,
    res_valid, out_valid && out_data.data_byte == $past(in_item_r.rx_byte))

endmodule

// File: hw/rtl/mpd_parser.sv
// Parser state and per-byte next-state / result logic.
`timescale 1ns / 1ps

module mpd_parser import mpd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  mpd_item_t   item,
  output mpd_result_t res
);

  phase_t            phase_r, phase_nxt;
  logic [7:0]        header_byte_r, header_byte_nxt;
  logic [LEN_W-1:0]  bytes_left_r, bytes_left_nxt;
  logic [LEN_W-1:0]  body_position_r, body_position_nxt;
  logic [2:0]        length_byte_count_r, length_byte_count_nxt;
  logic [15:0]       topic_length_r, topic_length_nxt;
  logic [15:0]       topic_left_r, topic_left_nxt;
  logic [15:0]       held_packet_id_r, held_packet_id_nxt;
  logic              return_code_ok_r, return_code_ok_nxt;
  logic              halted_r, halted_nxt;

  logic [7:0]        b;
  logic [3:0]        hdr_type;
  logic [1:0]        hdr_qos;
  logic [LEN_W-1:0]  len_group;
  logic [LEN_W-1:0]  bl_dec;
  logic [15:0]       tlen_full;
  logic              pend;

  assign b        = item.rx_byte;
  assign hdr_type = header_byte_r[7:4];
  assign hdr_qos  = (hdr_type == TYPE_PUBLISH) ? header_byte_r[2:1] : 2'd0;
  assign bl_dec   = bytes_left_r - LEN_W'(1);
  assign tlen_full = {topic_length_r[15:8], b};

  // 7-bit length group placed at its position, low group first
  always_comb begin
    case (length_byte_count_r[1:0])
      2'd0:    len_group = {21'd0, b[6:0]};
      2'd1:    len_group = {14'd0, b[6:0], 7'd0};
      2'd2:    len_group = {7'd0, b[6:0], 14'd0};
      default: len_group = {b[6:0], 21'd0};
    endcase
  end

  always_comb begin
    phase_nxt             = phase_r;
    header_byte_nxt       = header_byte_r;
    bytes_left_nxt        = bytes_left_r;
    body_position_nxt     = body_position_r;
    length_byte_count_nxt = length_byte_count_r;
    topic_length_nxt      = topic_length_r;
    topic_left_nxt        = topic_left_r;
    held_packet_id_nxt    = held_packet_id_r;
    return_code_ok_nxt    = return_code_ok_r;
    halted_nxt            = halted_r;
    pend                  = 1'b0;

    res             = '0;
    res.byte_role   = ROLE_DISCARD;
    res.data_byte   = b;
    res.event_res   = EV_NONE;

    if (halted_r) begin
      res.byte_role = ROLE_DISCARD;
    end else if (phase_r == PH_HEADER) begin
      res.byte_role         = ROLE_HEADER;
      res.packet_type       = b[7:4];
      res.qos_level         = (b[7:4] == TYPE_PUBLISH) ? b[2:1] : 2'd0;
      header_byte_nxt       = b;
      bytes_left_nxt        = '0;
      body_position_nxt     = '0;
      length_byte_count_nxt = '0;
      topic_length_nxt      = '0;
      topic_left_nxt        = '0;
      held_packet_id_nxt    = '0;
      return_code_ok_nxt    = 1'b0;
      phase_nxt             = PH_LENGTH;
    end else begin
      res.packet_type = hdr_type;
      res.qos_level   = hdr_qos;
      if (phase_r == PH_LENGTH) begin
        res.byte_role = ROLE_LENGTH;
        if (length_byte_count_r[2]) begin
          // fifth length byte: error, then discard until reset
          res.event_res = EV_LEN_ERR;
          halted_nxt    = 1'b1;
          phase_nxt     = PH_HEADER;
        end else begin
          bytes_left_nxt        = bytes_left_r | len_group;
          length_byte_count_nxt = length_byte_count_r + 3'd1;
          if (!b[7]) begin
            if (bytes_left_nxt == '0) begin
              pend = 1'b1;
            end else begin
              phase_nxt = (hdr_type == TYPE_PUBLISH) ? PH_TLEN_HI : PH_OTHER;
            end
          end
        end
      end else begin
        case (phase_r)
          PH_TLEN_HI: begin
            res.byte_role    = ROLE_TLEN;
            topic_length_nxt = {b, 8'h00};
            phase_nxt        = PH_TLEN_LO;
          end
          PH_TLEN_LO: begin
            res.byte_role    = ROLE_TLEN;
            topic_length_nxt = tlen_full;
            topic_left_nxt   = tlen_full;
            phase_nxt        = (tlen_full == 16'd0) ? PH_OTHER : PH_TOPIC;
          end
          PH_TOPIC: begin
            res.byte_role  = ROLE_TOPIC;
            topic_left_nxt = topic_left_r - 16'd1;
            if (topic_left_nxt == 16'd0) begin
              phase_nxt = (hdr_qos != 2'd0) ? PH_PID_HI : PH_PAYLOAD;
            end
          end
          PH_PID_HI: begin
            res.byte_role      = ROLE_PID;
            held_packet_id_nxt = {b, 8'h00};
            phase_nxt          = PH_PID_LO;
          end
          PH_PID_LO: begin
            res.byte_role      = ROLE_PID;
            held_packet_id_nxt = {held_packet_id_r[15:8], b};
            phase_nxt          = PH_PAYLOAD;
          end
          PH_PAYLOAD: begin
            res.byte_role = ROLE_PAYLOAD;
          end
          default: begin
            res.byte_role = ROLE_OTHER;
            phase_nxt     = PH_OTHER;
            // CONNACK return code is the second body byte
            if (body_position_r == LEN_W'(1)) begin
              return_code_ok_nxt = (b == 8'd0);
            end
          end
        endcase
        bytes_left_nxt    = bl_dec;
        body_position_nxt = body_position_r + LEN_W'(1);
        if (bl_dec == '0) begin
          pend = 1'b1;
        end
      end

      if (pend) begin
        res.packet_end = 1'b1;
        if (hdr_type == TYPE_CONNACK) begin
          res.event_res = (body_position_nxt == LEN_W'(2) && return_code_ok_nxt) ?
                          EV_CONNACK_OK : EV_CONNACK_REJ;
        end else if (hdr_type == TYPE_PUBLISH) begin
          if (phase_nxt == PH_PAYLOAD) begin
            res.event_res  = EV_PUB_DONE;
            res.ack_needed = (hdr_qos == QOS_1);
            res.packet_id  = (hdr_qos != 2'd0) ? held_packet_id_nxt : 16'd0;
          end else begin
            res.event_res = EV_PUB_DROP;
          end
        end else begin
          res.event_res = EV_OTHER_DONE;
        end
        phase_nxt = PH_HEADER;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && item.command == CMD_RESET)) begin
      phase_r             <= PH_HEADER;
      header_byte_r       <= '0;
      bytes_left_r        <= '0;
      body_position_r     <= '0;
      length_byte_count_r <= '0;
      topic_length_r      <= '0;
      topic_left_r        <= '0;
      held_packet_id_r    <= '0;
      return_code_ok_r    <= 1'b0;
      halted_r            <= 1'b0;
    end else if (step) begin
      phase_r             <= phase_nxt;
      header_byte_r       <= header_byte_nxt;
      bytes_left_r        <= bytes_left_nxt;
      body_position_r     <= body_position_nxt;
      length_byte_count_r <= length_byte_count_nxt;
      topic_length_r      <= topic_length_nxt;
      topic_left_r        <= topic_left_nxt;
      held_packet_id_r    <= held_packet_id_nxt;
      return_code_ok_r    <= return_code_ok_nxt;
      halted_r            <= halted_nxt;
    end
  end

endmodule

// File: hw/rtl/mpd_out_reg.sv
// Result register between the parser and the result channel.
`timescale 1ns / 1ps

module mpd_out_reg import mpd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load_valid,
  input  mpd_result_t load_data,
  output logic        can_load,
  input  logic        out_ready,
  output logic        out_valid,
  output mpd_result_t out_data
);

  logic        valid_r;
  mpd_result_t data_r;

  // free when empty or being drained this cycle
  assign can_load  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (can_load) begin
      valid_r <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && load_valid) begin
      data_r <= load_data;
    end
  end

endmodule
